// ===== hdl/tte_pkg.sv =====
// ----------------------------------------------------------------------------
// Text terminal cell engine package
// Shared constants, codes and types of the character-cell screen engine.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int unsigned MAX_COLS  = 128;
  localparam int unsigned MAX_ROWS  = 32;
  localparam int unsigned ATTR_BITS = 8;
  localparam int unsigned TAB_STOP  = 8;   // power of two
  localparam int unsigned TAB_BITS  = $clog2(TAB_STOP);
  localparam int unsigned CELLS     = MAX_COLS * MAX_ROWS;
  localparam int unsigned ADDR_W    = $clog2(CELLS);
  localparam int unsigned CELL_W    = 8 + ATTR_BITS;

  // Item kinds.
  localparam logic [2:0] KIND_BYTE   = 3'd0;
  localparam logic [2:0] KIND_ERASE  = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_INSERT = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  // Character codes.
  localparam logic [7:0] CODE_BS    = 8'd8;
  localparam logic [7:0] CODE_TAB   = 8'd9;
  localparam logic [7:0] CODE_LF    = 8'd10;
  localparam logic [7:0] CODE_CR    = 8'd13;
  localparam logic [7:0] CODE_SPACE = 8'd32;

  // Configuration register indexes.
  localparam logic [2:0] CFG_COLUMNS      = 3'd0;
  localparam logic [2:0] CFG_ROWS         = 3'd1;
  localparam logic [2:0] CFG_REGION_TOP   = 3'd2;
  localparam logic [2:0] CFG_REGION_BOT   = 3'd3;
  localparam logic [2:0] CFG_CUR_ATTR     = 3'd4;
  localparam logic [2:0] CFG_BLANK_ATTR   = 3'd5;

  localparam logic [7:0] RST_ATTR = 8'd7;
  localparam logic [CELL_W-1:0] CLEAR_CELL = {RST_ATTR[ATTR_BITS-1:0], CODE_SPACE};

  typedef struct packed {
    logic [7:0] columns;
    logic [5:0] rows;
    logic [4:0] region_top;
    logic [5:0] region_bottom;
    logic [7:0] current_attribute;
    logic [7:0] blank_attribute;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_in;
    logic [6:0] from_col;
    logic [4:0] from_row;
    logic [7:0] to_col;
    logic [5:0] to_row;
    logic [4:0] line_index;
  } item_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } res_t;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_CR, ACT_LF, ACT_BS, ACT_WRITE,
    ACT_ERASE, ACT_DELETE, ACT_INSERT, ACT_READ
  } act_e;

  typedef enum logic [2:0] {
    JOB_WRITE, JOB_UP, JOB_BLANK_BOT, JOB_DOWN, JOB_BLANK_LINE, JOB_ERASE, JOB_READ
  } job_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_PREP, ST_DECODE, ST_LF, ST_LO, ST_HI,
    ST_CLAMP, ST_RUN, ST_READ, ST_DONE
  } state_e;

  typedef struct packed {
    logic take;
    logic prep;
    logic clear_run;
    logic cur_cr;
    logic cur_bs;
    logic cur_adv;
    logic cur_lf;
    logic set_lo;
    logic set_hi;
    logic clamp;
    logic run;
    logic rd_cell;
    logic load_out;
    job_e job;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic empty;
    logic at_end;
    logic wrap;
    logic scroll;
    logic clear_done;
  } stat_t;

endpackage

// ===== hdl/tte_in_if.sv =====
// ----------------------------------------------------------------------------
// Text terminal cell engine input channel
// Valid/ready channel carrying one input item per beat.
// ----------------------------------------------------------------------------
interface tte_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] byte_in;
  logic [6:0] from_col;
  logic [4:0] from_row;
  logic [7:0] to_col;
  logic [5:0] to_row;
  logic [4:0] line_index;

  modport source (output valid, kind, byte_in, from_col, from_row, to_col, to_row,
                  line_index, input ready);
  modport sink (input valid, kind, byte_in, from_col, from_row, to_col, to_row,
                line_index, output ready);
endinterface

// ===== hdl/tte_out_if.sv =====
// ----------------------------------------------------------------------------
// Text terminal cell engine output channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface tte_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;

  modport source (output valid, cursor_col, cursor_row, cell_char, cell_attr,
                  input ready);
  modport sink (input valid, cursor_col, cursor_row, cell_char, cell_attr,
                output ready);
endinterface

// ===== hdl/text_terminal_cell_engine.sv =====
// ----------------------------------------------------------------------------
// Text terminal cell engine
// Character-cell screen store with cursor, scrolling, erase and cell read.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_if, one per beat when valid and ready are high.
// Each item yields exactly one result beat on out_if carrying the cursor
// after the item and, for a cell read, the character and attribute read.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i, one register per write; the user must write them only while
// the engine is idle, as the block itself does not enforce this.
// The engine handles one item at a time. Scrolls, line insert/delete and
// erases walk the store one cell per cycle; the cell memory has one write
// port and one read port.
// After reset the engine runs a clearing pass that fills all 4096 cells
// with a space and attribute 7; in_if.ready stays low meanwhile.
// A result waits in an output register while the receiver stalls; the next
// item may already be accepted and is held back only when its own result
// is ready and the register is still full.
// ----------------------------------------------------------------------------
module text_terminal_cell_engine
  import tte_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  tte_in_if.sink    in_if,
  tte_out_if.source out_if,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t  cfg_q;
  item_t item;
  cmd_t  cmd;
  stat_t stat;
  res_t  res;

  // Configuration registers take their reset values and are written by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns           <= 8'd80;
      cfg_q.rows              <= 6'd25;
      cfg_q.region_top        <= 5'd0;
      cfg_q.region_bottom     <= 6'd25;
      cfg_q.current_attribute <= RST_ATTR;
      cfg_q.blank_attribute   <= RST_ATTR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLUMNS:    cfg_q.columns           <= cfg_data_i;
        CFG_ROWS:       cfg_q.rows              <= cfg_data_i[5:0];
        CFG_REGION_TOP: cfg_q.region_top        <= cfg_data_i[4:0];
        CFG_REGION_BOT: cfg_q.region_bottom     <= cfg_data_i[5:0];
        CFG_CUR_ATTR:   cfg_q.current_attribute <= cfg_data_i;
        CFG_BLANK_ATTR: cfg_q.blank_attribute   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Gather the input beat into one item word for the datapath.
  assign item.kind       = in_if.kind;
  assign item.byte_in    = in_if.byte_in;
  assign item.from_col   = in_if.from_col;
  assign item.from_row   = in_if.from_row;
  assign item.to_col     = in_if.to_col;
  assign item.to_row     = in_if.to_row;
  assign item.line_index = in_if.line_index;

  tte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tte_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .item_i (item),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res)
  );

  assign out_if.cursor_col = res.cursor_col;
  assign out_if.cursor_row = res.cursor_row;
  assign out_if.cell_char  = res.cell_char;
  assign out_if.cell_attr  = res.cell_attr;

endmodule

// ===== hdl/tte_dp.sv =====
// ----------------------------------------------------------------------------
// Text terminal cell engine datapath
// Cell store, cursor, range address unit and sweep engine.
// ----------------------------------------------------------------------------
module tte_dp
  import tte_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  item_t item_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output res_t  res_o
);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_q;

  item_t             item_q;
  logic [7:0]        c_q;
  logic [5:0]        r_q, b_q;
  logic [4:0]        top_q;
  logic [6:0]        col_q;
  logic [4:0]        row_q;
  logic signed [15:0] lo_q, hi_q;
  logic [ADDR_W-1:0] cur_q, pw_addr_q;
  logic              pw_valid_q, rd_ok_q;
  res_t              res_q;

  logic [7:0]        c_eff;
  logic [5:0]        r_eff, b_eff;
  act_e              act;
  logic              is_tab, is_copy, down, empty, wrap, scroll, rd_ok;
  logic [7:0]        tab_next, e_col;
  logic [5:0]        row_inc;
  logic [5:0]        mrow;
  logic [7:0]        mcol;
  logic              dec;
  logic [13:0]       prod;
  logic signed [15:0] addr;
  logic [ADDR_W-1:0] end_addr, wa, ra;
  logic [CELL_W-1:0] fill, wd;
  logic              we, re, fill_we;

  // Effective screen geometry from the configuration.
  always_comb begin
    c_eff = cfg_i.columns;
    if (c_eff == 8'd0) c_eff = 8'd1;
    if (c_eff > 8'(MAX_COLS)) c_eff = 8'(MAX_COLS);
    r_eff = cfg_i.rows;
    if (r_eff == 6'd0) r_eff = 6'd1;
    if (r_eff > 6'(MAX_ROWS)) r_eff = 6'(MAX_ROWS);
    b_eff = cfg_i.region_bottom;
    if (b_eff > r_eff) b_eff = r_eff;
    if (b_eff == 6'd0) b_eff = 6'd1;
  end

  assign is_tab   = (item_q.byte_in == CODE_TAB);
  assign tab_next = {1'b0, col_q | 7'(TAB_STOP - 1)} + 8'd1;
  assign e_col    = is_tab ? ((tab_next < c_q) ? tab_next : c_q) : ({1'b0, col_q} + 8'd1);
  assign wrap     = (e_col >= c_q);
  assign row_inc  = {1'b0, row_q} + 6'd1;
  assign scroll   = (row_inc >= b_q);
  assign rd_ok    = ({1'b0, item_q.from_col} < c_q) && ({1'b0, item_q.from_row} < r_q);

  always_comb begin
    act = ACT_NONE;
    case (item_q.kind)
      KIND_BYTE: begin
        if (item_q.byte_in == CODE_CR) act = ACT_CR;
        else if (item_q.byte_in == CODE_LF) act = ACT_LF;
        else if (item_q.byte_in == CODE_BS) act = ACT_BS;
        else if (is_tab) act = (col_q[TAB_BITS-1:0] == '0) ? ACT_NONE : ACT_WRITE;
        else if (item_q.byte_in >= CODE_SPACE) act = ACT_WRITE;
      end
      KIND_ERASE:  act = ACT_ERASE;
      KIND_DELETE: act = ({1'b0, item_q.line_index} < b_q) ? ACT_DELETE : ACT_NONE;
      KIND_INSERT: act = ({1'b0, item_q.line_index} < b_q) ? ACT_INSERT : ACT_NONE;
      KIND_READ:   act = ACT_READ;
      default:     act = ACT_NONE;
    endcase
  end

  // Range bounds are all of the form row * columns + col - dec.
  always_comb begin
    mrow = '0;
    mcol = '0;
    dec  = 1'b0;
    case (cmd_i.job)
      JOB_WRITE: begin
        mrow = {1'b0, row_q};
        if (cmd_i.set_hi) begin
          mcol = e_col;
          dec  = 1'b1;
        end else begin
          mcol = {1'b0, col_q};
        end
      end
      JOB_UP: begin
        if (cmd_i.set_hi) begin
          mrow = b_q;
          dec  = 1'b1;
        end else begin
          mrow = {1'b0, top_q} + 6'd1;
        end
      end
      JOB_BLANK_BOT: begin
        if (cmd_i.set_hi) begin
          mrow = b_q;
          dec  = 1'b1;
        end else begin
          mrow = b_q - 6'd1;
        end
      end
      JOB_DOWN: begin
        if (cmd_i.set_hi) begin
          mrow = b_q - 6'd1;
          dec  = 1'b1;
        end else begin
          mrow = {1'b0, top_q};
        end
      end
      JOB_BLANK_LINE: begin
        if (cmd_i.set_hi) begin
          mrow = {1'b0, top_q} + 6'd1;
          dec  = 1'b1;
        end else begin
          mrow = {1'b0, top_q};
        end
      end
      JOB_ERASE: begin
        if (cmd_i.clamp) begin
          mrow = r_q;
          dec  = 1'b1;
        end else if (cmd_i.set_hi) begin
          mrow = item_q.to_row;
          mcol = item_q.to_col;
        end else begin
          mrow = {1'b0, item_q.from_row};
          mcol = {1'b0, item_q.from_col};
        end
      end
      default: begin
        mrow = {1'b0, item_q.from_row};
        mcol = {1'b0, item_q.from_col};
      end
    endcase
  end

  assign prod = {8'd0, mrow} * {6'd0, c_q};
  assign addr = $signed({2'b00, prod}) + $signed({8'h00, mcol}) - $signed({15'd0, dec});

  assign is_copy  = (cmd_i.job == JOB_UP) || (cmd_i.job == JOB_DOWN);
  assign down     = (cmd_i.job == JOB_DOWN);
  assign empty    = (lo_q > hi_q);
  assign end_addr = down ? lo_q[ADDR_W-1:0] : hi_q[ADDR_W-1:0];

  always_comb begin
    if (cmd_i.job == JOB_WRITE) begin
      fill = {cfg_i.current_attribute[ATTR_BITS-1:0], is_tab ? CODE_SPACE : item_q.byte_in};
    end else begin
      fill = {cfg_i.blank_attribute[ATTR_BITS-1:0], CODE_SPACE};
    end
  end

  assign fill_we = cmd_i.run && !empty && !is_copy;

  // Single write port: the sweep fill, the clearing pass or the second half of a copy.
  always_comb begin
    we = 1'b0;
    wa = cur_q;
    wd = fill;
    if (cmd_i.clear_run) begin
      we = 1'b1;
      wd = CLEAR_CELL;
    end else if (pw_valid_q) begin
      we = 1'b1;
      wa = pw_addr_q;
      wd = rd_q;
    end else if (fill_we) begin
      we = 1'b1;
    end
  end

  assign re = (cmd_i.run && !empty && is_copy) || cmd_i.rd_cell;
  assign ra = cmd_i.rd_cell ? lo_q[ADDR_W-1:0] : cur_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      cur_q      <= '0;
      pw_valid_q <= 1'b0;
    end else begin
      pw_valid_q <= cmd_i.run && !empty && is_copy;
      if (cmd_i.clear_run) begin
        cur_q <= cur_q + 1'b1;
      end else if (cmd_i.set_hi) begin
        cur_q <= down ? addr[ADDR_W-1:0] : lo_q[ADDR_W-1:0];
      end else if (cmd_i.run && !empty) begin
        cur_q <= down ? (cur_q - 1'b1) : (cur_q + 1'b1);
      end
      if (cmd_i.prep) begin
        col_q <= ({1'b0, col_q} >= c_eff) ? 7'(c_eff - 8'd1) : col_q;
        row_q <= ({1'b0, row_q} >= r_eff) ? 5'(r_eff - 6'd1) : row_q;
      end else if (cmd_i.cur_cr) begin
        col_q <= '0;
      end else if (cmd_i.cur_bs) begin
        if (col_q != '0) col_q <= col_q - 7'd1;
      end else if (cmd_i.cur_adv) begin
        col_q <= e_col[6:0];
      end else if (cmd_i.cur_lf) begin
        col_q <= '0;
        row_q <= scroll ? 5'(b_q - 6'd1) : row_inc[4:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) item_q <= item_i;
    if (cmd_i.prep) begin
      c_q     <= c_eff;
      r_q     <= r_eff;
      b_q     <= b_eff;
      top_q   <= (item_q.kind == KIND_BYTE) ? cfg_i.region_top : item_q.line_index;
      rd_ok_q <= 1'b0;
    end
    if (cmd_i.rd_cell) rd_ok_q <= rd_ok;
    if (cmd_i.set_lo) lo_q <= addr;
    if (cmd_i.set_hi) hi_q <= addr;
    if (cmd_i.clamp && (addr < hi_q)) hi_q <= addr;
    pw_addr_q <= down ? (cur_q + ADDR_W'(c_q)) : (cur_q - ADDR_W'(c_q));
    if (cmd_i.load_out) begin
      res_q.cursor_col <= col_q;
      res_q.cursor_row <= row_q;
      res_q.cell_char  <= rd_ok_q ? rd_q[7:0] : 8'd0;
      res_q.cell_attr  <= rd_ok_q ? 8'(rd_q[CELL_W-1:8]) : 8'd0;
    end
  end

  assign stat_o.act        = act;
  assign stat_o.empty      = empty;
  assign stat_o.at_end     = (cur_q == end_addr);
  assign stat_o.wrap       = wrap;
  assign stat_o.scroll     = scroll;
  assign stat_o.clear_done = (cur_q == ADDR_W'(CELLS - 1));
  assign res_o             = res_q;

`ifndef NO_ASSERTIONS
  // The reported cursor always lies on the screen.
  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (({1'b0, col_q} < c_q) && ({1'b0, row_q} < r_q)))
    else $error("cursor off screen at result");

  // A line feed leaves the cursor inside the scroll bottom.
  a_lf_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cur_lf |=> ({1'b0, row_q} < b_q))
    else $error("line feed left row past bottom");

  // A fill never collides with the trailing write of a copy.
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_we |-> !pw_valid_q)
    else $error("write port conflict");
`endif

endmodule

// ===== hdl/tte_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text terminal cell engine controller
// Sequences one item through decode, range setup and sweeps.
// ----------------------------------------------------------------------------
module tte_ctrl
  import tte_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  job_e   job_q, job_d;
  logic   out_valid_q, out_valid_d;
  logic   finish, slot_free;

  assign finish    = stat_i.empty || stat_i.at_end;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    unique case (state_q)
      ST_CLEAR:  if (stat_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_PREP;
      ST_PREP:   state_d = ST_DECODE;
      ST_DECODE: begin
        unique case (stat_i.act)
          ACT_LF:     state_d = ST_LF;
          ACT_WRITE:  begin job_d = JOB_WRITE; state_d = ST_LO; end
          ACT_ERASE:  begin job_d = JOB_ERASE; state_d = ST_LO; end
          ACT_DELETE: begin job_d = JOB_UP;    state_d = ST_LO; end
          ACT_INSERT: begin job_d = JOB_DOWN;  state_d = ST_LO; end
          ACT_READ:   begin job_d = JOB_READ;  state_d = ST_LO; end
          default:    state_d = ST_DONE;
        endcase
      end
      ST_LF: begin
        if (stat_i.scroll) begin
          job_d   = JOB_UP;
          state_d = ST_LO;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_LO:    state_d = (job_q == JOB_READ) ? ST_READ : ST_HI;
      ST_HI:    state_d = (job_q == JOB_ERASE) ? ST_CLAMP : ST_RUN;
      ST_CLAMP: state_d = ST_RUN;
      ST_RUN: begin
        if (finish) begin
          case (job_q)
            JOB_WRITE: state_d = stat_i.wrap ? ST_LF : ST_DONE;
            JOB_UP:    begin job_d = JOB_BLANK_BOT;  state_d = ST_LO; end
            JOB_DOWN:  begin job_d = JOB_BLANK_LINE; state_d = ST_LO; end
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    cmd_o.job = job_q;
    unique case (state_q)
      ST_CLEAR:  cmd_o.clear_run = 1'b1;
      ST_IDLE:   cmd_o.take = in_valid_i;
      ST_PREP:   cmd_o.prep = 1'b1;
      ST_DECODE: begin
        cmd_o.cur_cr = (stat_i.act == ACT_CR);
        cmd_o.cur_bs = (stat_i.act == ACT_BS);
      end
      ST_LF:    cmd_o.cur_lf = 1'b1;
      ST_LO:    cmd_o.set_lo = 1'b1;
      ST_HI:    cmd_o.set_hi = 1'b1;
      ST_CLAMP: cmd_o.clamp = 1'b1;
      ST_RUN: begin
        cmd_o.run     = 1'b1;
        cmd_o.cur_adv = finish && (job_q == JOB_WRITE);
      end
      ST_READ: cmd_o.rd_cell = 1'b1;
      ST_DONE: cmd_o.load_out = slot_free;
      default: cmd_o = '0;
    endcase
  end

  assign out_valid_d = cmd_o.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      job_q       <= JOB_WRITE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
